>>> sv/htlc_pkg.sv
// htlc_pkg: widths, register indexes, limits and shared types of the
// humidity/temperature linear calibration unit. No dependencies.

package htlc_pkg;

   localparam int RawW   = 16;
   localparam int PtW    = 7;
   localparam int DiffW  = 17;
   localparam int Dpt10W = 12;
   localparam int ProdW  = 29;
   localparam int MagW   = 27;
   localparam int DivW   = 16;
   localparam int BaseW  = 11;
   localparam int CsrIdxW = 4;
   localparam int NumCells = MagW;

   localparam logic [CsrIdxW-1:0] CSR_HUM_PT0  = 4'd0;
   localparam logic [CsrIdxW-1:0] CSR_HUM_PT1  = 4'd1;
   localparam logic [CsrIdxW-1:0] CSR_HUM_RAW0 = 4'd2;
   localparam logic [CsrIdxW-1:0] CSR_HUM_RAW1 = 4'd3;
   localparam logic [CsrIdxW-1:0] CSR_TMP_PT0  = 4'd4;
   localparam logic [CsrIdxW-1:0] CSR_TMP_PT1  = 4'd5;
   localparam logic [CsrIdxW-1:0] CSR_TMP_RAW0 = 4'd6;
   localparam logic [CsrIdxW-1:0] CSR_TMP_RAW1 = 4'd7;

   localparam int HUM_FULL_SCALE = 1000;
   localparam int TEMP_MAX = 32767;
   localparam int TEMP_MIN = -32768;

   localparam logic CH_HUM  = 1'b0;
   localparam logic CH_TEMP = 1'b1;

   typedef struct packed {
      logic [PtW-1:0]  hum_pt0;
      logic [PtW-1:0]  hum_pt1;
      logic [RawW-1:0] hum_raw0;
      logic [RawW-1:0] hum_raw1;
      logic [PtW-1:0]  tmp_pt0;
      logic [PtW-1:0]  tmp_pt1;
      logic [RawW-1:0] tmp_raw0;
      logic [RawW-1:0] tmp_raw1;
   } htlc_cfg_type;

   typedef struct packed {
      logic             op;
      logic             err;
      logic             qneg;
      logic [BaseW-1:0] base;
      logic [DivW-1:0]  divisor;
      logic [DivW-1:0]  rem;
      logic [MagW-1:0]  dq;
   } htlc_div_type;

endpackage

>>> sv/htlc_front.sv
// htlc_front: calibration point selection, numerator product and magnitude
// stages ahead of the divider chain. Depends on htlc_pkg.

module htlc_front (
   input  logic                  clock,
   input  logic                  reset,
   input  htlc_pkg::htlc_cfg_type cfg,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_op,
   input  logic [15:0]           req_raw_sample,
   output logic                  out_valid,
   output htlc_pkg::htlc_div_type out_data,
   input  logic                  out_stall
);
   import htlc_pkg::*;

   logic                     s1_valid_ff, s1_valid_in;
   logic                     s1_op_ff;
   logic signed [DiffW-1:0]  s1_diff_ff, diff_c;
   logic signed [Dpt10W-1:0] s1_dpt10_ff, dpt10_c;
   logic [DivW-1:0]          s1_div_ff, div_c;
   logic                     s1_neg_ff, neg_c;
   logic                     s1_err_ff, err_c;
   logic [BaseW-1:0]         s1_base_ff, base_c;

   logic                     s2_valid_ff, s2_valid_in;
   logic                     s2_op_ff;
   logic signed [ProdW-1:0]  s2_prod_ff, prod_c;
   logic [DivW-1:0]          s2_div_ff;
   logic                     s2_neg_ff;
   logic                     s2_err_ff;
   logic [BaseW-1:0]         s2_base_ff;

   logic                     s3_valid_ff, s3_valid_in;
   htlc_div_type             s3_data_ff, s3_data_in;

   logic s1_move, s2_move, s3_move;

   assign s3_move   = !s3_valid_ff || !out_stall;
   assign s2_move   = !s2_valid_ff || s3_move;
   assign s1_move   = !s1_valid_ff || s2_move;
   assign req_stall = !s1_move;

   assign s1_valid_in = s1_move ? req_valid : s1_valid_ff;
   assign s2_valid_in = s2_move ? s1_valid_ff : s2_valid_ff;
   assign s3_valid_in = s3_move ? s2_valid_ff : s3_valid_ff;

   // point selection and differences
   always_comb begin
      logic [PtW-1:0]          pt0;
      logic [PtW-1:0]          pt1;
      logic [RawW-1:0]         raw0;
      logic [RawW-1:0]         raw1;
      logic signed [7:0]       dpt;
      logic signed [Dpt10W-1:0] dpt_ext;
      logic signed [DiffW-1:0] span;
      logic [DiffW-1:0]        span_abs;
      if (req_op == CH_TEMP) begin
         pt0  = cfg.tmp_pt0;
         pt1  = cfg.tmp_pt1;
         raw0 = cfg.tmp_raw0;
         raw1 = cfg.tmp_raw1;
      end else begin
         pt0  = cfg.hum_pt0;
         pt1  = cfg.hum_pt1;
         raw0 = cfg.hum_raw0;
         raw1 = cfg.hum_raw1;
      end
      diff_c   = $signed({req_raw_sample[15], req_raw_sample}) - $signed({raw0[15], raw0});
      dpt      = $signed({1'b0, pt1}) - $signed({1'b0, pt0});
      dpt_ext  = {{4{dpt[7]}}, dpt};
      dpt10_c  = (dpt_ext <<< 3) + (dpt_ext <<< 1);
      span     = $signed({raw1[15], raw1}) - $signed({raw0[15], raw0});
      span_abs = span[DiffW-1] ? (17'd0 - span) : span;
      div_c    = span_abs[DivW-1:0];
      neg_c    = span[DiffW-1];
      err_c    = (span == 17'sd0);
      base_c   = {1'b0, pt0, 3'b000} + {3'b000, pt0, 1'b0};
   end

   assign prod_c = s1_diff_ff * s1_dpt10_ff;

   // magnitude and quotient sign
   always_comb begin
      logic [ProdW-1:0] mag;
      mag = s2_prod_ff[ProdW-1] ? (29'd0 - s2_prod_ff) : s2_prod_ff;
      s3_data_in         = s3_data_ff;
      if (s3_move) begin
         s3_data_in.op      = s2_op_ff;
         s3_data_in.err     = s2_err_ff;
         s3_data_in.qneg    = s2_prod_ff[ProdW-1] ^ s2_neg_ff;
         s3_data_in.base    = s2_base_ff;
         s3_data_in.divisor = s2_div_ff;
         s3_data_in.rem     = '0;
         s3_data_in.dq      = mag[MagW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         s1_op_ff    <= req_op;
         s1_diff_ff  <= diff_c;
         s1_dpt10_ff <= dpt10_c;
         s1_div_ff   <= div_c;
         s1_neg_ff   <= neg_c;
         s1_err_ff   <= err_c;
         s1_base_ff  <= base_c;
      end
      if (s2_move) begin
         s2_op_ff   <= s1_op_ff;
         s2_prod_ff <= prod_c;
         s2_div_ff  <= s1_div_ff;
         s2_neg_ff  <= s1_neg_ff;
         s2_err_ff  <= s1_err_ff;
         s2_base_ff <= s1_base_ff;
      end
      s3_data_ff <= s3_data_in;
   end

   assign out_valid = s3_valid_ff;
   assign out_data  = s3_data_ff;

endmodule

>>> sv/htlc_div_cell.sv
// htlc_div_cell: one restoring division step, one quotient bit per cell,
// registered towards the next cell. Depends on htlc_pkg.

module htlc_div_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_stall,
   input  htlc_pkg::htlc_div_type in_data,
   output logic                  out_valid,
   output htlc_pkg::htlc_div_type out_data,
   input  logic                  out_stall
);
   import htlc_pkg::*;

   logic         valid_ff, valid_in;
   htlc_div_type data_ff, data_in;
   logic         move;

   assign move     = !valid_ff || !out_stall;
   assign in_stall = !move;
   assign valid_in = move ? in_valid : valid_ff;

   always_comb begin
      logic [DivW:0] rem_sh;
      logic [DivW:0] rem_sub;
      logic          ge;
      rem_sh  = {in_data.rem, in_data.dq[MagW-1]};
      ge      = (rem_sh >= {1'b0, in_data.divisor});
      rem_sub = rem_sh - {1'b0, in_data.divisor};
      data_in = data_ff;
      if (move) begin
         data_in     = in_data;
         data_in.rem = ge ? rem_sub[DivW-1:0] : rem_sh[DivW-1:0];
         data_in.dq  = {in_data.dq[MagW-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

>>> sv/htlc_back.sv
// htlc_back: quotient sign, offset add, clamping and the response register.
// Depends on htlc_pkg.

module htlc_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_stall,
   input  htlc_pkg::htlc_div_type in_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_channel,
   output logic [15:0]           rsp_scaled_value,
   output logic                  rsp_clipped,
   output logic                  rsp_span_error
);
   import htlc_pkg::*;

   logic        rsp_valid_ff, rsp_valid_in;
   logic        channel_ff;
   logic [15:0] value_ff, value_in;
   logic        clip_ff, clip_in;
   logic        err_ff;
   logic        move;

   assign move         = !rsp_valid_ff || !rsp_stall;
   assign in_stall     = !move;
   assign rsp_valid_in = move ? in_valid : rsp_valid_ff;

   always_comb begin
      logic [MagW:0]            mag;
      logic [MagW:0]            qs;
      logic signed [ProdW-1:0]  sum;
      mag      = {1'b0, in_data.dq};
      qs       = in_data.qneg ? (28'd0 - mag) : mag;
      sum      = $signed({qs[MagW], qs}) + $signed({18'd0, in_data.base});
      value_in = sum[15:0];
      clip_in  = 1'b0;
      if (in_data.err) begin
         value_in = '0;
      end else if (in_data.op == CH_HUM) begin
         if (sum[ProdW-1]) begin
            value_in = '0;
            clip_in  = 1'b1;
         end else if (sum > 29'(HUM_FULL_SCALE)) begin
            value_in = 16'(HUM_FULL_SCALE);
            clip_in  = 1'b1;
         end
      end else begin
         if (sum > 29'(TEMP_MAX)) begin
            value_in = 16'(TEMP_MAX);
            clip_in  = 1'b1;
         end else if (sum < 29'(TEMP_MIN)) begin
            value_in = 16'(TEMP_MIN);
            clip_in  = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (move) begin
         channel_ff <= in_data.op;
         value_ff   <= value_in;
         clip_ff    <= clip_in;
         err_ff     <= in_data.err;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_channel      = channel_ff;
   assign rsp_scaled_value = value_ff;
   assign rsp_clipped      = clip_ff;
   assign rsp_span_error   = err_ff;

endmodule

>>> sv/humidity_temperature_linear_calibration_unit.sv
// humidity_temperature_linear_calibration_unit: top level, calibration
// registers, front stages, divider cell row and response stage.
// Depends on htlc_pkg, htlc_front, htlc_div_cell, htlc_back.
//
//   channel   direction  handshake             payload
//   req_      in         req_valid/req_stall   req_op, req_raw_sample
//   rsp_      out        rsp_valid/rsp_stall   rsp_channel, rsp_scaled_value,
//                                              rsp_clipped, rsp_span_error
//   csr_      in         csr_valid/csr_ready   csr_index, csr_wdata
//
// one request per cycle unless rsp_stall holds the pipeline: three front
// stages, 27 divider cells (one quotient bit each) and the response register
// every stage holds on its own, so bubbles close up under rsp_stall
// reset clears all valid flags and the calibration registers to zero
// csr_ready is always high; unknown indexes are dropped

module humidity_temperature_linear_calibration_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_op,
   input  logic [15:0] req_raw_sample,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_channel,
   output logic [15:0] rsp_scaled_value,
   output logic        rsp_clipped,
   output logic        rsp_span_error,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [3:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   import htlc_pkg::*;

   htlc_cfg_type cfg_ff, cfg_in;
   htlc_div_type chain_data  [0:NumCells];
   logic         chain_valid [0:NumCells];
   logic         chain_stall [0:NumCells];

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_HUM_PT0:  cfg_in.hum_pt0  = csr_wdata[PtW-1:0];
            CSR_HUM_PT1:  cfg_in.hum_pt1  = csr_wdata[PtW-1:0];
            CSR_HUM_RAW0: cfg_in.hum_raw0 = csr_wdata;
            CSR_HUM_RAW1: cfg_in.hum_raw1 = csr_wdata;
            CSR_TMP_PT0:  cfg_in.tmp_pt0  = csr_wdata[PtW-1:0];
            CSR_TMP_PT1:  cfg_in.tmp_pt1  = csr_wdata[PtW-1:0];
            CSR_TMP_RAW0: cfg_in.tmp_raw0 = csr_wdata;
            CSR_TMP_RAW1: cfg_in.tmp_raw1 = csr_wdata;
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   htlc_front u_front (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_op         (req_op),
      .req_raw_sample (req_raw_sample),
      .out_valid      (chain_valid[0]),
      .out_data       (chain_data[0]),
      .out_stall      (chain_stall[0])
   );

   for (genvar k = 0; k < NumCells; k++) begin : g_cell
      htlc_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (chain_valid[k]),
         .in_stall  (chain_stall[k]),
         .in_data   (chain_data[k]),
         .out_valid (chain_valid[k+1]),
         .out_data  (chain_data[k+1]),
         .out_stall (chain_stall[k+1])
      );
   end

   htlc_back u_back (
      .clock            (clock),
      .reset            (reset),
      .in_valid         (chain_valid[NumCells]),
      .in_stall         (chain_stall[NumCells]),
      .in_data          (chain_data[NumCells]),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_channel      (rsp_channel),
      .rsp_scaled_value (rsp_scaled_value),
      .rsp_clipped      (rsp_clipped),
      .rsp_span_error   (rsp_span_error)
   );

endmodule

>>> sv/htlc_checker.sv
// htlc_checker: port level checks of the calibration unit, bound to the
// top level. Depends on htlc_pkg and the top level's ports.

module htlc_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_channel,
   input logic [15:0] rsp_scaled_value,
   input logic        rsp_clipped,
   input logic        rsp_span_error
);
   import htlc_pkg::*;

   a_reset_empty : assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_scaled_value))
      else $error("stalled response changed");

   a_span_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_span_error |-> rsp_scaled_value == 16'd0 && !rsp_clipped)
      else $error("span error with non-zero value or clip");

   a_hum_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_channel == CH_HUM |->
         !rsp_scaled_value[15] && rsp_scaled_value <= 16'(HUM_FULL_SCALE))
      else $error("humidity out of range");

   a_hum_clip : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_channel == CH_HUM && rsp_clipped |->
         rsp_scaled_value == 16'd0 || rsp_scaled_value == 16'(HUM_FULL_SCALE))
      else $error("humidity clip not at a limit");

endmodule

bind humidity_temperature_linear_calibration_unit htlc_checker u_htlc_checker (.*);
